FILE: hdl/adcss_pkg.sv
// adcss_pkg: shared types, codes and constants for the adc single-shot sequencer
// used by adcss_step and adc_single_shot_sequencer; no dependencies
package adcss_pkg;

    // input word kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result word kinds
    localparam logic [1:0] OUT_WRITE  = 2'd0;
    localparam logic [1:0] OUT_READ   = 2'd1;
    localparam logic [1:0] OUT_FINISH = 2'd2;

    // finish status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ERROR   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // converter register pointers
    localparam logic PTR_CONV   = 1'b0;
    localparam logic PTR_CONFIG = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [1:0] CFG_GAIN     = 2'd1;
    localparam logic [1:0] CFG_RATE     = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

    // configuration reset values
    localparam logic [6:0] RST_DEV_ADDR = 7'd72;
    localparam logic [2:0] RST_GAIN     = 3'd2;
    localparam logic [2:0] RST_RATE     = 3'd4;
    localparam logic [7:0] RST_TIMEOUT  = 8'd50;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // sequencer phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WRITE = 4'b0010,
        PH_POLL  = 4'b0100,
        PH_CONV  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [2:0] gain;
        logic [2:0] rate;
        logic [7:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  channel;
        logic [1:0]  bus_status;
        logic [15:0] read_data;
    } item_t;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [7:0]         bus_address;
        logic               reg_pointer;
        logic [15:0]        write_data;
        logic [1:0]         status;
        logic signed [15:0] raw_code;
        logic [22:0]        voltage_uv;
    } result_t;

    // full scale in microvolts per gain code; upper codes share the smallest range
    function automatic logic [22:0] full_scale_uv(input logic [2:0] gain);
        logic [22:0] fs;
        case (gain)
            3'd0:    fs = 23'd6144000;
            3'd1:    fs = 23'd4096000;
            3'd2:    fs = 23'd2048000;
            3'd3:    fs = 23'd1024000;
            3'd4:    fs = 23'd512000;
            default: fs = 23'd256000;
        endcase
        return fs;
    endfunction

endpackage

FILE: hdl/adc_single_shot_sequencer.sv
// adc_single_shot_sequencer: host-side sequencer for one single-shot conversion
// data path: an accepted word is evaluated out of the input register and its result
// word is registered in the output register, which drives m_tvalid
// throughput: one input word per cycle; only a stalled result word holds the input
// reset: aresetn low at a clock edge empties both registers, returns the phase
// to idle, clears the tick count and loads the configuration defaults
module adc_single_shot_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // channel[2:0], bus_status[4:3], read_data[20:5], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // bus_address[7:0], reg_pointer[8], write_data[24:9],
                                   // status[26:25], raw_code[42:27], voltage_uv[65:43], zero
    output logic [1:0]  m_tuser    // out_kind[1:0]
);

    adcss_pkg::cfg_t    cfg_reg;
    logic               in_valid_reg;
    adcss_pkg::item_t   in_item_reg;
    adcss_pkg::phase_t  phase_reg;
    adcss_pkg::phase_t  phase_next;
    logic [15:0]        elapsed_reg;
    logic [15:0]        elapsed_next;
    logic               out_valid_reg;
    adcss_pkg::result_t out_result_reg;
    adcss_pkg::result_t step_result;
    logic               step_has_result;
    logic               out_free;
    logic               step_go;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dev_addr <= adcss_pkg::RST_DEV_ADDR;
            cfg_reg.gain     <= adcss_pkg::RST_GAIN;
            cfg_reg.rate     <= adcss_pkg::RST_RATE;
            cfg_reg.timeout  <= adcss_pkg::RST_TIMEOUT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                adcss_pkg::CFG_DEV_ADDR: cfg_reg.dev_addr <= cfg_wdata[6:0];
                adcss_pkg::CFG_GAIN:     cfg_reg.gain     <= cfg_wdata[2:0];
                adcss_pkg::CFG_RATE:     cfg_reg.rate     <= cfg_wdata[2:0];
                adcss_pkg::CFG_TIMEOUT:  cfg_reg.timeout  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // handshake: the held word moves on unless its result finds the output full
    assign out_free = !out_valid_reg || m_tready;
    assign step_go  = in_valid_reg && (!step_has_result || out_free);
    assign s_tready = !in_valid_reg || step_go;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind       <= s_tuser;
            in_item_reg.channel    <= s_tdata[2:0];
            in_item_reg.bus_status <= s_tdata[4:3];
            in_item_reg.read_data  <= s_tdata[20:5];
        end
    end

    adcss_step u_step (
        .cfg          (cfg_reg),
        .item         (in_item_reg),
        .phase        (phase_reg),
        .elapsed      (elapsed_reg),
        .phase_next   (phase_next),
        .elapsed_next (elapsed_next),
        .has_result   (step_has_result),
        .result       (step_result)
    );

    // phase and tick count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= adcss_pkg::PH_IDLE;
            elapsed_reg <= 16'd0;
        end else if (step_go) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step_go && step_has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step_go && step_has_result) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.out_kind;
    assign m_tdata  = {6'd0, out_result_reg.voltage_uv, out_result_reg.raw_code,
                       out_result_reg.status, out_result_reg.write_data,
                       out_result_reg.reg_pointer, out_result_reg.bus_address};

    // a finish word always leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_go && step_has_result && step_result.out_kind == adcss_pkg::OUT_FINISH)
        |=> phase_reg == adcss_pkg::PH_IDLE)
        else $error("finish word did not return phase to idle");

    // a config write request is only issued from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_go && step_has_result && step_result.out_kind == adcss_pkg::OUT_WRITE)
        |-> phase_reg == adcss_pkg::PH_IDLE)
        else $error("write request issued outside idle");

    // a word with a result is held while the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && step_has_result && out_valid_reg && !m_tready)
        |=> in_valid_reg && $stable(phase_reg) && $stable(elapsed_reg))
        else $error("word with pending result lost under stall");

endmodule

FILE: hdl/adcss_step.sv
// adcss_step: combinational phase update and result build for one input word
// depends on adcss_pkg
module adcss_step (
    input  adcss_pkg::cfg_t    cfg,
    input  adcss_pkg::item_t   item,
    input  adcss_pkg::phase_t  phase,
    input  logic [15:0]        elapsed,
    output adcss_pkg::phase_t  phase_next,
    output logic [15:0]        elapsed_next,
    output logic               has_result,
    output adcss_pkg::result_t result
);

    logic        do_finish;
    logic [1:0]  fin_status;
    logic [15:0] fin_raw;
    logic [15:0] cfg_word;
    logic [37:0] product;

    // config word: start, mux 4+channel, gain, single shot, rate, comparator off
    assign cfg_word = {1'b1, 1'b1, item.channel[1:0], cfg.gain, 1'b1, cfg.rate,
                       3'b000, 2'b11};

    // scale positive codes to microvolts, truncated
    assign product = item.read_data[14:0] * adcss_pkg::full_scale_uv(cfg.gain);

    // phase machine and request build
    always_comb begin
        phase_next   = phase;
        elapsed_next = elapsed;
        has_result   = 1'b0;
        do_finish    = 1'b0;
        fin_status   = adcss_pkg::ST_OK;
        fin_raw      = 16'd0;
        result.out_kind    = adcss_pkg::OUT_WRITE;
        result.bus_address = {cfg.dev_addr, 1'b0};
        result.reg_pointer = adcss_pkg::PTR_CONV;
        result.write_data  = 16'd0;
        result.status      = adcss_pkg::ST_OK;
        result.raw_code    = 16'sd0;
        result.voltage_uv  = 23'd0;

        case (item.kind)
            adcss_pkg::KIND_START: begin
                if (phase == adcss_pkg::PH_IDLE) begin
                    if (item.channel[2]) begin
                        do_finish  = 1'b1;
                        fin_status = adcss_pkg::ST_ERROR;
                    end else begin
                        phase_next         = adcss_pkg::PH_WRITE;
                        elapsed_next       = 16'd0;
                        has_result         = 1'b1;
                        result.out_kind    = adcss_pkg::OUT_WRITE;
                        result.reg_pointer = adcss_pkg::PTR_CONFIG;
                        result.write_data  = cfg_word;
                    end
                end
            end
            adcss_pkg::KIND_TICK: begin
                if (elapsed != adcss_pkg::ELAPSED_MAX) begin
                    elapsed_next = elapsed + 16'd1;
                end
            end
            adcss_pkg::KIND_DONE: begin
                if (phase != adcss_pkg::PH_IDLE) begin
                    if (item.bus_status != adcss_pkg::ST_OK) begin
                        do_finish  = 1'b1;
                        fin_status = item.bus_status;
                    end else begin
                        unique case (phase)
                            adcss_pkg::PH_WRITE: begin
                                phase_next         = adcss_pkg::PH_POLL;
                                elapsed_next       = 16'd0;
                                has_result         = 1'b1;
                                result.out_kind    = adcss_pkg::OUT_READ;
                                result.reg_pointer = adcss_pkg::PTR_CONFIG;
                            end
                            adcss_pkg::PH_POLL: begin
                                if (item.read_data[15]) begin
                                    phase_next         = adcss_pkg::PH_CONV;
                                    has_result         = 1'b1;
                                    result.out_kind    = adcss_pkg::OUT_READ;
                                    result.reg_pointer = adcss_pkg::PTR_CONV;
                                end else if (elapsed > {8'd0, cfg.timeout}) begin
                                    do_finish  = 1'b1;
                                    fin_status = adcss_pkg::ST_TIMEOUT;
                                end else begin
                                    has_result         = 1'b1;
                                    result.out_kind    = adcss_pkg::OUT_READ;
                                    result.reg_pointer = adcss_pkg::PTR_CONFIG;
                                end
                            end
                            adcss_pkg::PH_CONV: begin
                                do_finish = 1'b1;
                                fin_raw   = item.read_data;
                            end
                            default: begin
                                phase_next = adcss_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase

        // finish word closes the conversion
        if (do_finish) begin
            phase_next         = adcss_pkg::PH_IDLE;
            has_result         = 1'b1;
            result.out_kind    = adcss_pkg::OUT_FINISH;
            result.reg_pointer = adcss_pkg::PTR_CONV;
            result.write_data  = 16'd0;
            result.status      = fin_status;
            result.raw_code    = signed'(fin_raw);
            if (fin_status == adcss_pkg::ST_OK && !fin_raw[15] && fin_raw != 16'd0) begin
                result.voltage_uv = product[37:15];
            end
        end
    end

endmodule
